[rtl/hset_pkg.sv]
// ----------------------------------------------------------------------------
// hset_pkg
// Shared widths, table geometry, bucket reduction constants and row types
// for the hash set with fixed-way buckets.
// ----------------------------------------------------------------------------
package hset_pkg;

    // Field widths
    localparam int KEY_W  = 31;
    localparam int MODE_W = 2;

    // Table geometry
    localparam int NUM_BUCKETS = 1024;
    localparam int WAYS        = 4;
    localparam int BKT_W       = $clog2(NUM_BUCKETS);
    localparam int NB_W        = BKT_W + 1;

    // Bucket reduction: key mod NUM_BUCKETS by reciprocal multiply.
    // floor(2^RECIP_W / N) undershoots the quotient by at most one,
    // so the remainder needs a single compare and subtract.
    localparam int RECIP_W = 32;
    localparam int PROD_W  = KEY_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'd1 << RECIP_W) / NUM_BUCKETS);
    localparam logic [NB_W-1:0]  NB_VAL   = NB_W'(NUM_BUCKETS);
    localparam logic [BKT_W-1:0] BKT_LAST = BKT_W'(NUM_BUCKETS - 1);

    // Operation codes; the unused code behaves as contains
    typedef enum logic [MODE_W-1:0] {
        MODE_ADD      = 2'd0,
        MODE_CONTAINS = 2'd1,
        MODE_REMOVE   = 2'd2
    } mode_t;

    // One way of a bucket and one whole bucket row
    typedef struct packed {
        logic             vld;
        logic [KEY_W-1:0] key;
    } slot_t;

    typedef slot_t [WAYS-1:0] row_t;

    localparam int ROW_W = WAYS * (KEY_W + 1);

endpackage

[rtl/hset_ram.sv]
// ----------------------------------------------------------------------------
// hset_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read; read data holds while re is low.
// ----------------------------------------------------------------------------
module hset_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/hash_set_add_contains_remove.sv]
// ----------------------------------------------------------------------------
// hash_set_add_contains_remove
// Set of 31-bit keys in a table of buckets with a fixed number of ways.
// Bucket = key mod NUM_BUCKETS; each transaction adds, tests or removes
// one key and returns whether it was present and whether an add overflowed.
//
//  Channel | Dir | Ports                       | Contents
//  --------+-----+-----------------------------+---------------------------
//  input   | in  | s_tvalid s_tready s_tdata   | tdata: key; tuser: mode
//          |     | s_tuser                     |
//  result  | out | m_tvalid m_tready m_tdata   | tdata: found, bucket_full
//
// One item at a time, no new one accepted until it is done: the accepting
// edge, then two registered multiplies and a fold for the bucket reduction,
// one registered bucket row read, and the row update written back.
// After reset a clearing pass writes every bucket row with s_tready low.
// A result waits in the output register; the next item is accepted
// meanwhile and its update stalls only if that result is still untaken.
// ----------------------------------------------------------------------------
module hash_set_add_contains_remove (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] key, [31] unused
    input  logic [1:0]  s_tuser,   // [1:0] mode

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] found, [1] bucket_full, [7:2] zero
);

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_MUL    = 7'b0000100,
        ST_SCALE  = 7'b0001000,
        ST_FOLD   = 7'b0010000,
        ST_READ   = 7'b0100000,
        ST_UPDATE = 7'b1000000
    } state_t;

    state_t                           state_reg, state_next;
    logic [hset_pkg::BKT_W-1:0]       clr_reg, clr_next;
    logic                             out_valid_reg, out_valid_next;

    logic [hset_pkg::KEY_W-1:0]       key_reg;
    hset_pkg::mode_t                  mode_reg;
    logic [hset_pkg::PROD_W-1:0]      prod_reg, prod_next;
    logic [hset_pkg::KEY_W-1:0]       qn_reg, qn_next;
    logic [hset_pkg::BKT_W-1:0]       bucket_reg, bucket_next;
    logic                             found_reg, full_reg;

    logic                             in_fire;
    logic                             update_go;
    logic [hset_pkg::KEY_W-1:0]       q_est;
    logic [hset_pkg::KEY_W+hset_pkg::NB_W-1:0] qn_full;
    logic [hset_pkg::KEY_W-1:0]       rem_raw, rem_fix;

    hset_pkg::row_t                   row_rd, row_new;
    logic [hset_pkg::WAYS-1:0]        hit_vec, free_vec, free_first;
    logic                             found_c, full_c;

    logic                             ram_we, ram_re;
    logic [hset_pkg::BKT_W-1:0]       ram_waddr;
    logic [hset_pkg::ROW_W-1:0]       ram_wdata, ram_rdata;

    assign in_fire   = s_tvalid && s_tready;
    assign update_go = (state_reg == ST_UPDATE) && (!out_valid_reg || m_tready);

    // Bucket reduction datapath
    always_comb begin
        prod_next = hset_pkg::PROD_W'(key_reg) * hset_pkg::PROD_W'(hset_pkg::RECIP);
        q_est     = prod_reg[hset_pkg::PROD_W-1:hset_pkg::RECIP_W];
        qn_full   = (hset_pkg::KEY_W + hset_pkg::NB_W)'(q_est)
                  * (hset_pkg::KEY_W + hset_pkg::NB_W)'(hset_pkg::NB_VAL);
        qn_next   = qn_full[hset_pkg::KEY_W-1:0];
        rem_raw   = key_reg - qn_reg;
        if (rem_raw >= hset_pkg::KEY_W'(hset_pkg::NUM_BUCKETS)) begin
            rem_fix = rem_raw - hset_pkg::KEY_W'(hset_pkg::NUM_BUCKETS);
        end else begin
            rem_fix = rem_raw;
        end
        bucket_next = rem_fix[hset_pkg::BKT_W-1:0];
    end

    // Bucket row lookup and modify
    always_comb begin
        row_rd = hset_pkg::row_t'(ram_rdata);
        for (int w = 0; w < hset_pkg::WAYS; w++) begin
            hit_vec[w]  = row_rd[w].vld && (row_rd[w].key == key_reg);
            free_vec[w] = !row_rd[w].vld;
        end
        free_first = free_vec & (~free_vec + hset_pkg::WAYS'(1));
        found_c    = |hit_vec;
        full_c     = 1'b0;
        row_new    = row_rd;
        unique case (mode_reg)
            hset_pkg::MODE_ADD: begin
                if (!found_c) begin
                    full_c = !(|free_vec);
                    for (int w = 0; w < hset_pkg::WAYS; w++) begin
                        if (free_first[w]) begin
                            row_new[w].vld = 1'b1;
                            row_new[w].key = key_reg;
                        end
                    end
                end
            end
            hset_pkg::MODE_REMOVE: begin
                for (int w = 0; w < hset_pkg::WAYS; w++) begin
                    if (hit_vec[w]) begin
                        row_new[w].vld = 1'b0;
                    end
                end
            end
            default: begin
                // contains and the unused code leave the row as it is
            end
        endcase
    end

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + hset_pkg::BKT_W'(1);
                if (clr_reg == hset_pkg::BKT_LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_FOLD;
            ST_FOLD:  state_next = ST_READ;
            ST_READ:  state_next = ST_UPDATE;
            ST_UPDATE: begin
                if (update_go) begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            key_reg  <= s_tdata[hset_pkg::KEY_W-1:0];
            mode_reg <= hset_pkg::mode_t'(s_tuser);
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= prod_next;
        end
        if (state_reg == ST_SCALE) begin
            qn_reg <= qn_next;
        end
        if (state_reg == ST_FOLD) begin
            bucket_reg <= bucket_next;
        end
        if (update_go) begin
            found_reg <= found_c;
            full_reg  <= full_c;
        end
    end

    // Bucket table: one row per bucket, clearing pass shares the write port
    assign ram_we    = (state_reg == ST_CLEAR) || update_go;
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_reg : bucket_reg;
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : hset_pkg::ROW_W'(row_new);
    assign ram_re    = (state_reg == ST_READ);

    hset_ram #(
        .WIDTH (hset_pkg::ROW_W),
        .DEPTH (hset_pkg::NUM_BUCKETS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (bucket_reg),
        .rdata (ram_rdata)
    );

    // Ports
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, full_reg, found_reg};

    // Checks
    a_full_not_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("found and bucket_full both set");

    a_bucket_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ) |-> (bucket_reg <= hset_pkg::BKT_LAST))
        else $error("bucket index out of range");

    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FOLD) |->
            (rem_raw < hset_pkg::KEY_W'(2 * hset_pkg::NUM_BUCKETS)))
        else $error("reduction remainder not below twice the bucket count");

    a_update_result: assert property (@(posedge aclk) disable iff (!aresetn)
        update_go |=> (m_tvalid && (state_reg == ST_IDLE)))
        else $error("row update without a result");

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (!s_tready && (state_reg == ST_MUL)))
        else $error("transaction accepted while busy");

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb - hash set add / contains / remove testbench
// Drives add, contains and remove transactions into the set and predicts
// each result with a private copy of the bucket table. Every result is
// compared with the oldest prediction. The run goes through directed corner
// cases, then random phases with no idling, sender gaps, receiver stalls
// and both together.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS      = hset_pkg::NUM_BUCKETS * hset_pkg::WAYS;
    localparam int STALL_MAX  = 4000;  // cycles with no transaction at all
    localparam int DRAIN_WAIT = 20;
    localparam int ITEMS_PER_PHASE = 175;
    localparam int POOL_KEYS  = 40;
    localparam int POOL_BKTS  = 8;

    // Mode code outside the defined operations; behaves as contains
    localparam logic [hset_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    // Predicted outcome of one transaction
    typedef struct {
        logic found;
        logic bucket_full;
    } set_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: private bucket table plus queue of predicted results
    // ------------------------------------------------------------------------
    class hset_scoreboard;
        bit                         slot_vld[SLOTS];
        logic [hset_pkg::KEY_W-1:0] slot_keys[SLOTS];
        set_result_t                pending_results[$];
        int                         mismatches;

        function new();
            foreach (slot_vld[i]) slot_vld[i] = 1'b0;
            foreach (slot_keys[i]) slot_keys[i] = '0;
            mismatches = 0;
        endfunction

        // Apply one accepted operation to the table and queue its outcome
        function void apply_op(logic [hset_pkg::MODE_W-1:0] op,
                               logic [hset_pkg::KEY_W-1:0] key);
            int unsigned base;
            int          hit_way;
            int          free_slot;
            set_result_t res;
            base      = (key % hset_pkg::NUM_BUCKETS) * hset_pkg::WAYS;
            hit_way   = -1;
            free_slot = -1;
            for (int w = hset_pkg::WAYS - 1; w >= 0; w--) begin
                if (slot_vld[base + w] && slot_keys[base + w] == key) hit_way = w;
                if (!slot_vld[base + w]) free_slot = w;
            end
            res.found       = (hit_way >= 0);
            res.bucket_full = 1'b0;
            if (hset_pkg::mode_t'(op) == hset_pkg::MODE_ADD) begin
                if (hit_way < 0) begin
                    if (free_slot >= 0) begin
                        slot_vld[base + free_slot]  = 1'b1;
                        slot_keys[base + free_slot] = key;
                    end else begin
                        res.bucket_full = 1'b1;
                    end
                end
            end else if (hset_pkg::mode_t'(op) == hset_pkg::MODE_REMOVE) begin
                if (hit_way >= 0) slot_vld[base + hit_way] = 1'b0;
            end
            // anything else, unused code included, only tests membership
            pending_results = {pending_results, res};
        endfunction

        // Compare one result transaction with the oldest prediction
        function void check_result(logic found, logic bucket_full);
            set_result_t exp_res;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing pending: found=%0b full=%0b",
                             $realtime, found, bucket_full);
                return;
            end
            exp_res = pending_results.pop_front();
            if (found !== exp_res.found || bucket_full !== exp_res.bucket_full) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch: found exp %0b got %0b, full exp %0b got %0b",
                             $realtime, exp_res.found, found,
                             exp_res.bucket_full, bucket_full);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;

    hset_scoreboard sb = new();

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int quiet_cycles    = 0;

    logic [hset_pkg::KEY_W-1:0] key_pool[POOL_KEYS];

    hash_set_add_contains_remove DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock, 10 ns period
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Receiver backpressure, changed at the falling edge
    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata[0], m_tdata[1]);
    end

    // Watchdog on cycles with no transaction on either channel
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_MAX) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // One input transaction; entered and left at a falling edge
    task automatic send_op(logic [hset_pkg::MODE_W-1:0] op,
                           logic [hset_pkg::KEY_W-1:0] key);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {1'($urandom_range(1)), key};  // top bit is don't-care
        s_tuser  = op;
        do @(posedge aclk); while (!s_tready);
        sb.apply_op(op, key);
        @(negedge aclk);
    endtask

    // Hold off until every predicted result has been seen
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (sb.pending_results.size() != 0) @(negedge aclk);
    endtask

    // Keys crowded into a few buckets so that buckets fill and empty
    task automatic build_pool();
        logic [hset_pkg::BKT_W-1:0] bkts[POOL_BKTS];
        foreach (bkts[i])
            bkts[i] = hset_pkg::BKT_W'($urandom_range(hset_pkg::NUM_BUCKETS - 1));
        foreach (key_pool[i])
            key_pool[i] = hset_pkg::KEY_W'(bkts[i % POOL_BKTS]) +
                          hset_pkg::KEY_W'(hset_pkg::NUM_BUCKETS) *
                          hset_pkg::KEY_W'($urandom_range(2097151));
    endtask

    task automatic random_phase(int items);
        int                          r;
        logic [hset_pkg::MODE_W-1:0] op;
        logic [hset_pkg::KEY_W-1:0]  key;
        build_pool();
        for (int n = 0; n < items; n++) begin
            r = $urandom_range(99);
            if (r < 40)      op = hset_pkg::MODE_ADD;
            else if (r < 65) op = hset_pkg::MODE_CONTAINS;
            else if (r < 95) op = hset_pkg::MODE_REMOVE;
            else             op = MODE_UNUSED;
            if ($urandom_range(99) < 85) key = key_pool[$urandom_range(POOL_KEYS - 1)];
            else                         key = hset_pkg::KEY_W'($urandom);
            send_op(op, key);
        end
    endtask

    // Main sequence
    initial begin
        logic [hset_pkg::KEY_W-1:0] kmax;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        kmax     = '1;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty table, duplicate add, largest key, unused code
        send_op(hset_pkg::MODE_CONTAINS, '0);
        send_op(hset_pkg::MODE_ADD, '0);
        send_op(hset_pkg::MODE_ADD, '0);
        send_op(hset_pkg::MODE_CONTAINS, '0);
        send_op(hset_pkg::MODE_ADD, kmax);
        send_op(MODE_UNUSED, kmax);
        send_op(hset_pkg::MODE_REMOVE, kmax);
        send_op(hset_pkg::MODE_REMOVE, kmax);
        send_op(MODE_UNUSED, 31'd77);
        // Directed: fill one bucket, overflow it, free a way, refill
        for (int w = 0; w <= hset_pkg::WAYS; w++)
            send_op(hset_pkg::MODE_ADD,
                    hset_pkg::KEY_W'(5 + w * hset_pkg::NUM_BUCKETS));
        send_op(hset_pkg::MODE_CONTAINS,
                hset_pkg::KEY_W'(5 + hset_pkg::WAYS * hset_pkg::NUM_BUCKETS));
        send_op(hset_pkg::MODE_REMOVE, hset_pkg::KEY_W'(5 + hset_pkg::NUM_BUCKETS));
        send_op(hset_pkg::MODE_ADD,
                hset_pkg::KEY_W'(5 + hset_pkg::WAYS * hset_pkg::NUM_BUCKETS));
        send_op(hset_pkg::MODE_ADD,
                hset_pkg::KEY_W'(5 + (hset_pkg::WAYS + 1) * hset_pkg::NUM_BUCKETS));
        send_op(hset_pkg::MODE_CONTAINS,
                hset_pkg::KEY_W'(5 + hset_pkg::WAYS * hset_pkg::NUM_BUCKETS));
        send_op(hset_pkg::MODE_REMOVE, '0);
        wait_drained();

        // Random phases with different idling
        random_phase(ITEMS_PER_PHASE);
        wait_drained();
        sender_idle_pct = 55;
        random_phase(ITEMS_PER_PHASE);
        wait_drained();
        sender_idle_pct = 0;
        recv_stall_pct  = 55;
        random_phase(ITEMS_PER_PHASE);
        wait_drained();
        sender_idle_pct = 11;
        recv_stall_pct  = 11;
        random_phase(ITEMS_PER_PHASE);

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
